FILE: design/owik_pkg.sv
// ----------------------------------------------------------------------------
// owik_pkg: shared types and constants of the omni wheel inverse kinematics
// Item layouts, register indexes, the CORDIC arctangent table and the widths
// of the fixed-point datapath.
// ----------------------------------------------------------------------------
package owik_pkg;

  // Angle resolution inside the block and fraction bits of the cosine.
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned TRIG_BITS  = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned GAIN_W     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_GAIN = 2'd1;
  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = 24'd106807;
  localparam logic [GAIN_W-1:0] ROTATION_GAIN_RST = 24'd673239;

  // CORDIC in Q30 with a fixed number of micro-rotations.
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 33;
  localparam logic signed [XW-1:0] X_INIT = 34'sd652032874;

  // Datapath widths.
  localparam int unsigned CW   = TRIG_BITS + 2;   // clamped cosine, +-2^TRIG_BITS
  localparam int unsigned SCW  = 16 + CW;         // speed * cosine
  localparam int unsigned PPW  = SCW + 13;        // partial product with a 12-bit gain half
  localparam int unsigned LCW  = SCW + 25;        // speed * cosine * linear gain
  localparam int unsigned V1W  = LCW - TRIG_BITS; // linear term in Q24
  localparam int unsigned RTW  = 16 + 25;         // rotation term in Q24
  localparam int unsigned SUMW = ((V1W > RTW) ? V1W : RTW) + 1;
  localparam int unsigned V2W  = SUMW - 16;
  localparam int unsigned OUT_W = 20;

  // Pipeline: one input stage, the CORDIC stages, then six arithmetic stages.
  localparam int unsigned PIPE_LAST = CORDIC_ITERS + 6;

  localparam int unsigned ANG_SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int unsigned ANG_SHR = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

  // Mounting angle of wheel 1 (45 degrees); the others lie whole quadrants away.
  localparam logic [ANGLE_BITS-1:0] WHEEL_BASE_OFF = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  typedef struct packed {
    logic signed [15:0] speed_mm_s;
    logic [15:0]        direction_angle;
    logic signed [15:0] rotation_deg_s;
    logic [15:0]        heading_angle;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] wheel0_target;
    logic signed [OUT_W-1:0] wheel1_target;
    logic signed [OUT_W-1:0] wheel2_target;
    logic signed [OUT_W-1:0] wheel3_target;
    logic                    saturated;
  } res_t;

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [15:0] a);
    logic [31:0] w;
    w = ({16'b0, a} << ANG_SHL) >> ANG_SHR;
    return w[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/owik_if.sv
// ----------------------------------------------------------------------------
// owik_if: valid/ready channels of the omni wheel inverse kinematics
// Request channel carrying a motion request, result channel carrying the
// four wheel targets and the clamp flag.
// ----------------------------------------------------------------------------
interface owik_req_if;
  logic           valid;
  logic           ready;
  owik_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface owik_res_if;
  logic           valid;
  logic           ready;
  owik_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/omni_wheel_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics: field-oriented targets for four omni wheels
// One pipelined CORDIC gives the cosine of the wheel-1 phase; the other
// wheels are whole quadrants away and reuse it. Gains are Q24 registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_i     in         valid/ready        speed, direction, rotation, heading
//  res_o     out        valid/ready        wheel0..3 targets, saturated
//  cfg       in         cfg_we_i, no wait  cfg_idx_i, cfg_wdata_i
//
//  One item can enter in every cycle unless the output stalls; the pipeline is
//  the 30 CORDIC stages plus one input and six arithmetic stages.
//  The whole pipeline advances together whenever the output register is empty
//  or being taken, so a stall holds every item in place.
//  Reset clears the valid bits and restores both gain registers.
// ----------------------------------------------------------------------------
module omni_wheel_inverse_kinematics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owik_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [owik_pkg::GAIN_W-1:0]    cfg_wdata_i,
  owik_req_if.sink                      req_i,
  owik_res_if.source                    res_o
);
  import owik_pkg::*;

  localparam logic signed [XW-1:0]   COS_RND = XW'(1) <<< (29 - TRIG_BITS);
  localparam logic signed [XW-1:0]   TMAX    = XW'(1) <<< TRIG_BITS;
  localparam logic signed [LCW-1:0]  LC_RND  = LCW'(1) <<< (TRIG_BITS - 1);
  localparam logic signed [SUMW-1:0] SUM_RND = SUMW'(1) <<< 15;
  localparam logic signed [V2W-1:0]  OUT_MAX = V2W'(524287);
  localparam logic signed [V2W-1:0]  OUT_MIN = -V2W'(524288);

  logic [GAIN_W-1:0] lin_gain_q, rot_gain_q;
  logic [PIPE_LAST:0] vld_q;
  logic adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= LINEAR_GAIN_RST;
      rot_gain_q <= ROTATION_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINEAR_GAIN:   lin_gain_q <= cfg_wdata_i;
        REG_ROTATION_GAIN: rot_gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv         = !vld_q[PIPE_LAST] || res_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAST-1:0], req_i.valid};
    end
  end

  // Input stage: phase of wheel 1, quadrant fold so that |z| <= 2^29.
  logic [ANGLE_BITS-1:0] ang_a;
  logic [31:0]           phase;

  assign ang_a = WHEEL_BASE_OFF - to_angle(req_i.data.direction_angle)
               - to_angle(req_i.data.heading_angle);
  assign phase = {ang_a, {(32 - ANGLE_BITS){1'b0}}};

  logic signed [XW-1:0] cx_q [CORDIC_ITERS+1];
  logic signed [XW-1:0] cy_q [CORDIC_ITERS+1];
  logic signed [ZW-1:0] cz_q [CORDIC_ITERS+1];
  logic [1:0]           cq_q [CORDIC_ITERS+1];
  logic signed [15:0]   sp_q [CORDIC_ITERS+1];
  logic signed [15:0]   rt_q [CORDIC_ITERS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= X_INIT;
      cy_q[0] <= '0;
      cz_q[0] <= ZW'($signed(phase[29:0]));
      cq_q[0] <= phase[31:30] + {1'b0, phase[29]};
      sp_q[0] <= $signed(req_i.data.speed_mm_s);
      rt_q[0] <= $signed(req_i.data.rotation_deg_s);
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    assign at = $signed({1'b0, atan_entry(i)});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!cz_q[i][ZW-1]) begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + at;
        end
        cq_q[i+1] <= cq_q[i];
        sp_q[i+1] <= sp_q[i];
        rt_q[i+1] <= rt_q[i];
      end
    end
  end

  // Per-wheel cosine: pick +-x or +-y by quadrant, round and clamp.
  logic signed [CW-1:0]  c_q    [4];
  logic signed [SCW-1:0] sc_q   [4];
  logic signed [PPW-1:0] pplo_q [4];
  logic signed [PPW-1:0] pphi_q [4];
  logic signed [LCW-1:0] lc_q   [4];
  logic signed [V1W-1:0] v1_q   [4];
  logic signed [15:0]    sp_r_q;
  logic signed [15:0]    rot_r_q, rot_1_q, rot_2_q;
  logic signed [RTW-1:0] rterm_3_q, rterm_4_q;
  res_t                  res_q;

  logic signed [XW-1:0]  cos_sel [4];
  logic signed [XW-1:0]  cos_rnd [4];
  logic [1:0]            wq      [4];
  logic signed [V2W-1:0] v2      [4];
  logic signed [OUT_W-1:0] tgt   [4];
  logic [3:0]            clamp;
  logic signed [SUMW-1:0] sum    [4];

  // Quadrant offsets of wheels 0..3 relative to wheel 1.
  localparam logic [1:0] WHEEL_QOFF [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

  for (genvar k = 0; k < 4; k++) begin : g_wheel
    always_comb begin
      wq[k] = cq_q[CORDIC_ITERS] + WHEEL_QOFF[k];
      case (wq[k])
        2'd0:    cos_sel[k] = cx_q[CORDIC_ITERS];
        2'd1:    cos_sel[k] = -cy_q[CORDIC_ITERS];
        2'd2:    cos_sel[k] = -cx_q[CORDIC_ITERS];
        default: cos_sel[k] = cy_q[CORDIC_ITERS];
      endcase
      cos_rnd[k] = (cos_sel[k] + COS_RND) >>> (30 - TRIG_BITS);
      if (cos_rnd[k] > TMAX) begin
        cos_rnd[k] = TMAX;
      end else if (cos_rnd[k] < -TMAX) begin
        cos_rnd[k] = -TMAX;
      end
    end

    always_comb begin
      sum[k] = SUMW'(v1_q[k]) + SUMW'(rterm_4_q) + SUM_RND;
      v2[k]  = V2W'(sum[k] >>> 16);
      if (v2[k] > OUT_MAX) begin
        tgt[k]   = OUT_W'(OUT_MAX);
        clamp[k] = 1'b1;
      end else if (v2[k] < OUT_MIN) begin
        tgt[k]   = OUT_W'(OUT_MIN);
        clamp[k] = 1'b1;
      end else begin
        tgt[k]   = v2[k][OUT_W-1:0];
        clamp[k] = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[k]    <= cos_rnd[k][CW-1:0];
        sc_q[k]   <= SCW'(sp_r_q) * SCW'(c_q[k]);
        pplo_q[k] <= PPW'(sc_q[k]) * PPW'($signed({1'b0, lin_gain_q[11:0]}));
        pphi_q[k] <= PPW'(sc_q[k]) * PPW'($signed({1'b0, lin_gain_q[23:12]}));
        lc_q[k]   <= (LCW'(pphi_q[k]) <<< 12) + LCW'(pplo_q[k]);
        v1_q[k]   <= V1W'((lc_q[k] + LC_RND) >>> TRIG_BITS);
      end
    end
  end

  // Shared registers of the arithmetic stages; the rotation term is formed
  // alongside the wide product sum.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_r_q    <= sp_q[CORDIC_ITERS];
      rot_r_q   <= rt_q[CORDIC_ITERS];
      rot_1_q   <= rot_r_q;
      rot_2_q   <= rot_1_q;
      rterm_3_q <= RTW'(rot_2_q) * RTW'($signed({1'b0, rot_gain_q}));
      rterm_4_q <= rterm_3_q;
      res_q.wheel0_target <= tgt[0];
      res_q.wheel1_target <= tgt[1];
      res_q.wheel2_target <= tgt[2];
      res_q.wheel3_target <= tgt[3];
      res_q.saturated     <= |clamp;
    end
  end

  assign res_o.valid = vld_q[PIPE_LAST];
  assign res_o.data  = res_q;

endmodule
